// ===== rtl/core/uart_rb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UART ring buffer package
// Transaction types, request codes and ring control structs shared by the
// ring buffer modules.
// ----------------------------------------------------------------------------
package uart_rb_pkg;

  localparam int LEVEL_W = 6;
  localparam logic [7:0] EMPTY_READ_DATA = 8'hFF;

  typedef enum logic [2:0] {
    REQ_RX_BYTE    = 3'd0,
    REQ_HOST_READ  = 3'd1,
    REQ_HOST_WRITE = 3'd2,
    REQ_TX_READY   = 3'd3,
    REQ_RX_CLEAR   = 3'd4
  } req_type_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic       tx_ready;
  } uart_rb_in_t;

  typedef struct packed {
    logic [7:0]         rx_data;
    logic               rx_valid;
    logic [LEVEL_W-1:0] rx_level;
    logic               rx_overrun;
    logic               tx_valid;
    logic [7:0]         tx_byte;
    logic               tx_irq_enable;
  } uart_rb_out_t;

  // Update request for one ring in the execute cycle.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_cmd_t;

  // Ring occupancy seen before the update.
  typedef struct packed {
    logic empty;
    logic full;
    logic single;
  } ring_stat_t;

endpackage : uart_rb_pkg
`default_nettype wire

// ===== rtl/core/uart_rb_ring.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UART ring buffer: one byte ring
// Synchronous byte memory with head and tail pointers. The oldest byte is
// read into a register in the cycle before the ring is updated.
// ----------------------------------------------------------------------------
module uart_rb_ring
  import uart_rb_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               rd_en,
  input  wire ring_cmd_t          cmd,
  input  wire logic [7:0]         wr_data,
  output logic [7:0]              rd_data,
  output ring_stat_t              stat,
  output logic [LEVEL_W-1:0]      level_nxt
);

  localparam int PW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = PW + 1;
  localparam logic [PW-1:0]    LAST    = PW'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic [PW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [PW-1:0] head_inc, tail_inc;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W+LEVEL_W-1:0] cnt_ext;

  assign head_inc = (head_r == LAST) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST) ? '0 : tail_r + 1'b1;

  assign stat.empty  = (head_r == tail_r);
  assign stat.full   = (head_inc == tail_r);
  assign stat.single = (tail_inc == head_r);

  always_comb begin
    if (cmd.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
    end else begin
      head_nxt = cmd.push ? head_inc : head_r;
      tail_nxt = cmd.pop  ? tail_inc : tail_r;
    end
  end

  // Occupancy after the update, reported modulo the level field width.
  always_comb begin
    cnt = {1'b0, head_nxt} - {1'b0, tail_nxt};
    if (head_nxt < tail_nxt) begin
      cnt = cnt + DEPTH_C;
    end
    cnt_ext   = {{LEVEL_W{1'b0}}, cnt};
    level_nxt = cnt_ext[LEVEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.clear) begin
      mem[head_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[tail_r];
    end
  end

  assign rd_data = rd_data_r;

endmodule : uart_rb_ring
`default_nettype wire

// ===== rtl/core/uart_tx_rx_ring_buffers.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// UART transmit and receive ring buffers
// Byte rings between a UART line interface and a host, with overrun
// handling on receive and direct hand-off or queuing on transmit.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is accepted at a rising edge where start is high and busy
//   is low. in_item carries the request type, the data byte and the
//   transmitter status sampled for this transaction.
//   Every transaction yields exactly one result on out_res, marked by a
//   one-cycle out_valid strobe. The receiver cannot stall the block, so the
//   result is simply presented for that cycle.
//   Each transaction has an accept and an execute step: the accept edge
//   reads the oldest byte of both ring memories into registers, and the
//   following execute cycle updates pointers, writes the memory and
//   registers the result. busy is high during the execute cycle, so no new
//   transaction is accepted until it ends; the read-then-write of each
//   ring memory is the reason. out_valid rises at the edge that ends the
//   execute cycle, and the result is taken at the next edge.
//   Each ring holds DEPTH-1 bytes. A received byte into a full ring drops
//   the oldest byte and flags rx_overrun. A host write into a full transmit
//   ring first hands the oldest queued byte to the transmitter.
//   Synchronous reset empties both rings and clears the interrupt enable;
//   ring memory contents are left as they are and are never used before
//   being written.
// ----------------------------------------------------------------------------
module uart_tx_rx_ring_buffers
  import uart_rb_pkg::*;
#(
  parameter int RX_DEPTH = 64,
  parameter int TX_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire uart_rb_in_t in_item,
  output logic             out_valid,
  output uart_rb_out_t     out_res
);

  // Execute-stage flag and the latched transaction.
  logic         exec_r;
  uart_rb_in_t  item_r;
  logic         accept;

  // Transmit interrupt enable.
  logic         irq_r, irq_nxt;

  // Result register; only the strobe needs a reset.
  logic         out_valid_r;
  uart_rb_out_t out_res_r, res_nxt;

  ring_cmd_t    rx_cmd, tx_cmd;
  ring_stat_t   rx_stat, tx_stat;
  logic [7:0]   rx_rd_data, tx_rd_data;
  logic [LEVEL_W-1:0] rx_level_nxt;
  logic [LEVEL_W-1:0] tx_level_nxt;

  assign busy   = exec_r;
  assign accept = start && !exec_r;

  uart_rb_ring #(
    .DEPTH(RX_DEPTH)
  ) u_rx_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .cmd       (rx_cmd),
    .wr_data   (item_r.data_byte),
    .rd_data   (rx_rd_data),
    .stat      (rx_stat),
    .level_nxt (rx_level_nxt)
  );

  uart_rb_ring #(
    .DEPTH(TX_DEPTH)
  ) u_tx_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .cmd       (tx_cmd),
    .wr_data   (item_r.data_byte),
    .rd_data   (tx_rd_data),
    .stat      (tx_stat),
    .level_nxt (tx_level_nxt)
  );

  // Execute cycle: decide the ring updates and build the result. Ring
  // commands are only issued while a transaction is in the execute stage.
  always_comb begin
    rx_cmd  = '0;
    tx_cmd  = '0;
    irq_nxt = irq_r;
    res_nxt = '0;

    if (exec_r) begin
      unique case (item_r.req_type)
        REQ_RX_BYTE: begin
          // A full ring loses its oldest byte to make room.
          rx_cmd.push        = 1'b1;
          rx_cmd.pop         = rx_stat.full;
          res_nxt.rx_overrun = rx_stat.full;
        end
        REQ_HOST_READ: begin
          if (rx_stat.empty) begin
            res_nxt.rx_data = EMPTY_READ_DATA;
          end else begin
            res_nxt.rx_data  = rx_rd_data;
            res_nxt.rx_valid = 1'b1;
            rx_cmd.pop       = 1'b1;
          end
        end
        REQ_HOST_WRITE: begin
          if (tx_stat.empty && item_r.tx_ready) begin
            // Idle transmitter and nothing queued: hand over directly.
            res_nxt.tx_valid = 1'b1;
            res_nxt.tx_byte  = item_r.data_byte;
          end else begin
            if (tx_stat.full) begin
              res_nxt.tx_valid = 1'b1;
              res_nxt.tx_byte  = tx_rd_data;
              tx_cmd.pop       = 1'b1;
            end
            tx_cmd.push = 1'b1;
            irq_nxt     = 1'b1;
          end
        end
        REQ_TX_READY: begin
          if (!tx_stat.empty) begin
            res_nxt.tx_valid = 1'b1;
            res_nxt.tx_byte  = tx_rd_data;
            tx_cmd.pop       = 1'b1;
            // The last queued byte leaves: the ring drains.
            if (tx_stat.single) begin
              irq_nxt = 1'b0;
            end
          end
        end
        REQ_RX_CLEAR: begin
          rx_cmd.clear = 1'b1;
        end
        default: begin
        end
      endcase
    end

    res_nxt.rx_level      = rx_level_nxt;
    res_nxt.tx_irq_enable = irq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exec_r      <= 1'b0;
      irq_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      exec_r      <= accept;
      irq_r       <= irq_nxt;
      out_valid_r <= exec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (exec_r) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // An accepted transaction occupies the execute stage in the next cycle.
  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not enter the execute stage");

  // Every accepted transaction yields its result through exec_r and out_valid_r.
  a_accept_result : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted transaction produced no result");

  // A result never overlaps the execute stage of the next transaction.
  a_result_spacing : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe overlaps a busy execute cycle");

  // A successful host read cannot also report an overrun or a send.
  a_read_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.rx_valid) |-> (!out_res.rx_overrun && !out_res.tx_valid))
    else $error("host read result mixed with receive or transmit activity");

  // With the interrupt enable clear, nothing is left in the transmit ring.
  a_irq_tx_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !irq_nxt |-> (tx_level_nxt == '0))
    else $error("transmit ring holds bytes while the interrupt enable is clear");

endmodule : uart_tx_rx_ring_buffers
`default_nettype wire

// ===== verif/tb_uart_tx_rx_ring_buffers.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UART ring buffer testbench
// Drives request transactions into the UART receive and transmit rings and
// checks every result against a cycle-free predictor of both rings. The run
// covers directed corner cases, ring fills past full on both sides and mixed
// random traffic under two sender idle ratios.
// ----------------------------------------------------------------------------
module tb_uart_tx_rx_ring_buffers
  import uart_rb_pkg::*;
();

  localparam int RX_DEPTH       = 64;
  localparam int TX_DEPTH       = 64;
  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 7;
  // The result strobe follows the accept edge through the execute and result
  // registers, so SETTLE_CYCLES after the last expected result catch a stray one.
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 4000;

  // Request codes that the block does not decode; they must leave all state
  // untouched and still produce a result.
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  logic         clk;
  logic         rst_n;
  logic         start;
  logic         busy;
  uart_rb_in_t  in_item;
  logic         out_valid;
  uart_rb_out_t out_res;

  uart_tx_rx_ring_buffers #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state. Pointers are kept as plain integers modulo the ring
  // depth; each ring holds depth minus one bytes, so head equal to tail means
  // empty and head plus one equal to tail means full.
  // --------------------------------------------------------------------------
  logic [7:0]  rx_ring_mem [RX_DEPTH];
  logic [7:0]  tx_ring_mem [TX_DEPTH];
  int unsigned rx_wr_ptr;
  int unsigned rx_rd_ptr;
  int unsigned tx_wr_ptr;
  int unsigned tx_rd_ptr;
  logic        tx_irq_en_model;

  // Results still owed by the block, oldest first.
  uart_rb_out_t expected_results [$];

  int sender_idle_pct = 0;
  int mismatches      = 0;
  int stall_cycles    = 0;
  int n_items         = 0;
  int n_directed      = 0;
  int n_results       = 0;
  int n_overruns      = 0;
  int n_tx_handoffs   = 0;
  int n_empty_reads   = 0;
  int n_clears        = 0;

  // Takes the oldest queued transmit byte. When this empties the ring, the
  // transmit-empty interrupt enable drops.
  function automatic logic [7:0] tx_ring_pop();
    logic [7:0] b;
    b = tx_ring_mem[tx_rd_ptr];
    tx_rd_ptr = (tx_rd_ptr + 1) % TX_DEPTH;
    if (tx_rd_ptr == tx_wr_ptr) tx_irq_en_model = 1'b0;
    return b;
  endfunction

  // Applies one accepted transaction to the predicted ring state and returns
  // the result the block must report for it.
  function automatic uart_rb_out_t predict_ring_result(uart_rb_in_t item);
    uart_rb_out_t res;
    int unsigned  nxt;
    int unsigned  level;
    res = '0;
    case (item.req_type)
      REQ_RX_BYTE: begin
        // A byte from the line always lands; on a full ring the oldest byte
        // is pushed out and the overrun flag reports the loss.
        rx_ring_mem[rx_wr_ptr] = item.data_byte;
        rx_wr_ptr = (rx_wr_ptr + 1) % RX_DEPTH;
        if (rx_wr_ptr == rx_rd_ptr) begin
          rx_rd_ptr = (rx_rd_ptr + 1) % RX_DEPTH;
          res.rx_overrun = 1'b1;
        end
      end
      REQ_HOST_READ: begin
        if (rx_wr_ptr == rx_rd_ptr) begin
          res.rx_data = EMPTY_READ_DATA;
        end else begin
          res.rx_data  = rx_ring_mem[rx_rd_ptr];
          res.rx_valid = 1'b1;
          rx_rd_ptr = (rx_rd_ptr + 1) % RX_DEPTH;
        end
      end
      REQ_HOST_WRITE: begin
        if (tx_wr_ptr == tx_rd_ptr && item.tx_ready) begin
          // Empty ring and an idle transmitter: the byte bypasses the ring.
          res.tx_valid = 1'b1;
          res.tx_byte  = item.data_byte;
        end else begin
          nxt = (tx_wr_ptr + 1) % TX_DEPTH;
          // A full ring makes room by sending its oldest byte, whatever the
          // transmitter status says.
          if (nxt == tx_rd_ptr) begin
            res.tx_byte  = tx_ring_pop();
            res.tx_valid = 1'b1;
          end
          tx_ring_mem[tx_wr_ptr] = item.data_byte;
          tx_wr_ptr = nxt;
          tx_irq_en_model = 1'b1;
        end
      end
      REQ_TX_READY: begin
        if (tx_wr_ptr != tx_rd_ptr) begin
          res.tx_byte  = tx_ring_pop();
          res.tx_valid = 1'b1;
        end
      end
      REQ_RX_CLEAR: begin
        rx_wr_ptr = 0;
        rx_rd_ptr = 0;
      end
      default: begin
      end
    endcase
    level = (rx_wr_ptr + RX_DEPTH - rx_rd_ptr) % RX_DEPTH;
    res.rx_level      = level[LEVEL_W-1:0];
    res.tx_irq_enable = tx_irq_en_model;
    return res;
  endfunction

  function automatic void check_field(string fname, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want_v, got_v);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard. Both sides are sampled at the rising edge, before the
  // nonblocking updates of that edge land, so the values seen are the ones
  // the block itself sampled. The result check runs before the prediction of
  // a transaction accepted at the same edge, which keeps the queue in order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    uart_rb_out_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: result 0x%0h arrived with no transaction pending", $time, out_res);
      end else begin
        want = expected_results.pop_front();
        n_results++;
        check_field("rx_data", want.rx_data, out_res.rx_data);
        check_field("rx_valid", want.rx_valid, out_res.rx_valid);
        check_field("rx_level", want.rx_level, out_res.rx_level);
        check_field("rx_overrun", want.rx_overrun, out_res.rx_overrun);
        check_field("tx_valid", want.tx_valid, out_res.tx_valid);
        check_field("tx_byte", want.tx_byte, out_res.tx_byte);
        check_field("tx_irq_enable", want.tx_irq_enable, out_res.tx_irq_enable);
      end
    end
    if (rst_n && start && !busy) begin
      want = predict_ring_result(in_item);
      expected_results.push_back(want);
      n_items++;
      if (want.rx_overrun) n_overruns++;
      if (want.tx_valid) n_tx_handoffs++;
      if (in_item.req_type == REQ_HOST_READ && !want.rx_valid) n_empty_reads++;
      if (in_item.req_type == REQ_RX_CLEAR) n_clears++;
    end
  end

  // The watchdog ends a run in which neither a transaction nor a result has
  // moved for too long; a healthy run never gets near the limit.
  always @(posedge clk) begin : watchdog
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, stall_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sending side. start stays high from one transaction to the next unless
  // the sender decides to idle, so it is never lowered and raised within the
  // same time step. The task returns at the edge that accepted the item.
  // --------------------------------------------------------------------------
  task automatic send_op(input logic [2:0] req, input logic [7:0] data, input logic ready);
    uart_rb_in_t item;
    item.req_type  = req;
    item.data_byte = data;
    item.tx_ready  = ready;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
  endtask

  // Holds the sender off until every owed result has been checked.
  task automatic wait_results_drained();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Hand-picked transactions: field extremes, every request code, reads and
  // ready events on empty rings, the direct hand-off, queuing behind a busy
  // transmitter, interrupt enable set and clear, and a clear of the receive
  // ring with bytes still in it.
  task automatic test_directed_cases();
    send_op(REQ_HOST_READ, 8'h00, 1'b0);
    send_op(REQ_TX_READY, 8'hFF, 1'b1);
    send_op(REQ_RX_BYTE, 8'h00, 1'b1);
    send_op(REQ_RX_BYTE, 8'hFF, 1'b0);
    send_op(REQ_HOST_READ, 8'hFF, 1'b1);
    send_op(REQ_HOST_READ, 8'h00, 1'b0);
    send_op(REQ_HOST_WRITE, 8'hA5, 1'b1);
    send_op(REQ_HOST_WRITE, 8'h5A, 1'b0);
    send_op(REQ_HOST_WRITE, 8'hFF, 1'b1);
    send_op(REQ_TX_READY, 8'h00, 1'b0);
    send_op(REQ_TX_READY, 8'h00, 1'b1);
    send_op(REQ_TX_READY, 8'h00, 1'b0);
    for (int r = REQ_UNUSED_LO; r <= REQ_UNUSED_HI; r++) send_op(3'(r), 8'hFF, 1'b1);
    send_op(REQ_RX_BYTE, 8'h3C, 1'b0);
    send_op(REQ_RX_BYTE, 8'hC3, 1'b1);
    send_op(REQ_RX_CLEAR, 8'hFF, 1'b1);
    send_op(REQ_HOST_READ, 8'h00, 1'b1);
    send_op(REQ_HOST_WRITE, 8'h00, 1'b0);
    send_op(REQ_UNUSED_HI, 8'h00, 1'b0);
    send_op(REQ_TX_READY, 8'hFF, 1'b1);
    n_directed = n_items + 1;
  endtask

  // Fills the receive ring past full with random bytes and a sprinkling of
  // reads, so the overrun path runs at varying pointer positions, then reads
  // it dry and a little beyond.
  task automatic test_rx_overrun();
    int unsigned fill_n;
    fill_n = $urandom_range(RX_DEPTH, RX_DEPTH + 16);
    for (int i = 0; i < fill_n; i++) begin
      if ($urandom_range(99) < 8) send_op(REQ_HOST_READ, 8'($urandom), 1'($urandom));
      else send_op(REQ_RX_BYTE, 8'($urandom), 1'($urandom));
    end
    for (int i = 0; i < RX_DEPTH + 2; i++) send_op(REQ_HOST_READ, 8'($urandom), 1'($urandom));
  endtask

  // Queues host bytes behind a mostly busy transmitter until the transmit
  // ring overflows into forced sends, then drains it with ready events.
  task automatic test_tx_backlog();
    int unsigned fill_n;
    fill_n = $urandom_range(TX_DEPTH, TX_DEPTH + 16);
    for (int i = 0; i < fill_n; i++) begin
      if ($urandom_range(99) < 6) send_op(REQ_TX_READY, 8'($urandom), 1'($urandom));
      else send_op(REQ_HOST_WRITE, 8'($urandom), $urandom_range(99) < 10);
    end
    for (int i = 0; i < TX_DEPTH + 2; i++) send_op(REQ_TX_READY, 8'($urandom), 1'($urandom));
  endtask

  // Interleaved traffic on both rings, with rare clears and undecoded codes.
  task automatic test_mixed_traffic(input int count);
    int unsigned pick;
    logic [2:0]  req;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 26) req = REQ_RX_BYTE;
      else if (pick < 50) req = REQ_HOST_READ;
      else if (pick < 72) req = REQ_HOST_WRITE;
      else if (pick < 94) req = REQ_TX_READY;
      else if (pick < 97) req = REQ_RX_CLEAR;
      else req = 3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
      send_op(req, 8'($urandom), 1'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence. Reset is applied once. The sender idles rarely in the
  // first stretch, often in the second and never in the last; the
  // result side has no stall to exercise.
  // --------------------------------------------------------------------------
  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    rx_wr_ptr = 0;
    rx_rd_ptr = 0;
    tx_wr_ptr = 0;
    tx_rd_ptr = 0;
    tx_irq_en_model = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 8;
    test_directed_cases();
    test_rx_overrun();
    // Let the block run completely dry before the next stretch.
    wait_results_drained();

    sender_idle_pct = 74;
    test_tx_backlog();
    test_mixed_traffic(100);

    sender_idle_pct = 0;
    test_mixed_traffic(110);
    test_rx_overrun();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end

    $display("Run covered %0d transactions (%0d hand-picked) and checked %0d results.",
             n_items, n_directed - 1, n_results);
    $display("Seen: %0d receive overruns, %0d transmit hand-offs, %0d empty reads, %0d clears.",
             n_overruns, n_tx_handoffs, n_empty_reads, n_clears);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
